// File: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants
// Fixed-point format, opcodes and the job and stage records that are used
// by the front, the queue and the back of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int DATA_W        = 32;
    localparam int DIV_W         = DATA_W + FRACTION_BITS;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int NSTG          = DIV_W + 2;

    typedef enum logic [3:0] {
        F_ADD      = 4'd0,
        F_SUB      = 4'd1,
        F_MUL      = 4'd2,
        F_DIV      = 4'd3,
        F_GT       = 4'd4,
        F_LT       = 4'd5,
        F_GE       = 4'd6,
        F_LE       = 4'd7,
        F_EQ       = 4'd8,
        F_NE       = 4'd9,
        F_MIN      = 4'd10,
        F_MAX      = 4'd11,
        F_INC      = 4'd12,
        F_DEC      = 4'd13,
        F_FROM_INT = 4'd14,
        F_TO_INT   = 4'd15
    } t_func;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } t_kind;

    // One classified item. For a multiply opa/opb are the signed operands,
    // for a divide they are the magnitudes of dividend and divisor.
    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  value;
        logic               cmp;
        logic               dz;
        logic               neg;
        logic [DATA_W-1:0]  opa;
        logic [DATA_W-1:0]  opb;
    } t_job;

    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  value;
        logic               cmp;
        logic               dz;
        logic               neg;
        logic [DATA_W-1:0]  rem;
        logic [DIV_W-1:0]   dq;
        logic [DATA_W-1:0]  mb;
    } t_stg;

endpackage

`default_nettype wire

// File: rtl/fpa_if.sv
// ----------------------------------------------------------------------------
// fpa_if: channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpa_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] value;
    logic        compare_true;
    logic        divide_by_zero;

    modport source (output valid, value, compare_true, divide_by_zero, input ready);
    modport sink   (input valid, value, compare_true, divide_by_zero, output ready);
endinterface

`default_nettype wire

// File: rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: request decode
// Accepts request beats, works out the simple operations and prepares
// multiply and divide jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front
    import fpa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fpa_req_if.sink     i_req,
    input  wire logic   i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    logic  r_vld;
    t_job  r_job;
    t_job  n_job;
    logic  take;
    logic  signed [DATA_W-1:0] a;
    logic  signed [DATA_W-1:0] b;
    logic  lt_ab;
    logic  lt_ba;

    assign o_push      = r_vld && !i_q_full;
    assign i_req.ready = !r_vld || !i_q_full;
    assign take        = i_req.valid && i_req.ready;
    assign o_job       = r_job;

    assign a     = i_req.operand_a;
    assign b     = i_req.operand_b;
    assign lt_ab = a < b;
    assign lt_ba = b < a;

    always_comb begin
        n_job       = '0;
        n_job.kind  = K_SIMPLE;
        n_job.opa   = a;
        n_job.opb   = b;
        case (i_req.func)
            F_ADD:      n_job.value = a + b;
            F_SUB:      n_job.value = a - b;
            F_MUL:      n_job.kind  = K_MUL;
            F_DIV: begin
                n_job.kind = K_DIV;
                n_job.dz   = (b == '0);
                n_job.neg  = a[DATA_W-1] ^ b[DATA_W-1];
                n_job.opa  = a[DATA_W-1] ? (~a + 1'b1) : a;
                n_job.opb  = b[DATA_W-1] ? (~b + 1'b1) : b;
            end
            F_GT:       n_job.cmp   = lt_ba;
            F_LT:       n_job.cmp   = lt_ab;
            F_GE:       n_job.cmp   = !lt_ab;
            F_LE:       n_job.cmp   = !lt_ba;
            F_EQ:       n_job.cmp   = (a == b);
            F_NE:       n_job.cmp   = (a != b);
            F_MIN:      n_job.value = lt_ab ? a : b;
            F_MAX:      n_job.value = lt_ba ? a : b;
            F_INC:      n_job.value = a + 1'b1;
            F_DEC:      n_job.value = a - 1'b1;
            F_FROM_INT: n_job.value = a << FRACTION_BITS;
            F_TO_INT:   n_job.value = a >>> FRACTION_BITS;
            default:    n_job.value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fpa_queue.sv
// ----------------------------------------------------------------------------
// fpa_queue: job queue
// Short first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_queue
    import fpa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_job        i_job,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_job        o_job
);

    t_job               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QPTR_W:0]    r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: execution pipeline
// Multiplies in one stage, divides one quotient bit per stage, and holds
// the finished result in its last stage, which drives the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_back
    import fpa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_empty,
    input  t_job        i_job,
    output logic        o_pop,
    fpa_rsp_if.source   o_rsp
);

    localparam int LAST = NSTG - 1;

    logic               r_vld [NSTG];
    t_stg               r_stg [NSTG];
    logic signed [2*DATA_W-1:0] r_prod;
    logic               adv;
    logic signed [2*DATA_W-1:0] prod_sh;
    t_stg               n_last;

    // The whole pipeline moves together; it holds only when the result
    // in the last stage is not taken.
    assign adv   = !r_vld[LAST] || o_rsp.ready;
    assign o_pop = adv && !i_q_empty;

    assign prod_sh = r_prod >>> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= o_pop;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stg[0].kind  <= i_job.kind;
            r_stg[0].value <= i_job.value;
            r_stg[0].cmp   <= i_job.cmp;
            r_stg[0].dz    <= i_job.dz;
            r_stg[0].neg   <= i_job.neg;
            r_stg[0].rem   <= '0;
            r_stg[0].dq    <= DIV_W'(i_job.opa) << FRACTION_BITS;
            r_stg[0].mb    <= i_job.opb;
            r_prod         <= $signed(i_job.opa) * $signed(i_job.opb);
        end
    end

    // One restoring division step per stage.
    for (genvar g = 1; g <= DIV_W; g++) begin : g_div
        t_stg             n_stg;
        logic [DATA_W:0]  sh;
        logic [DATA_W:0]  diff;
        logic             qbit;

        always_comb begin
            n_stg = r_stg[g-1];
            sh    = {r_stg[g-1].rem, r_stg[g-1].dq[DIV_W-1]};
            diff  = sh - {1'b0, r_stg[g-1].mb};
            qbit  = (sh >= {1'b0, r_stg[g-1].mb});
            n_stg.rem = qbit ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
            n_stg.dq  = {r_stg[g-1].dq[DIV_W-2:0], qbit};
            if (g == 1 && r_stg[g-1].kind == K_MUL) begin
                n_stg.value = prod_sh[DATA_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_stg[g] <= n_stg;
            end
        end
    end

    always_comb begin
        n_last = r_stg[LAST-1];
        if (r_stg[LAST-1].kind == K_DIV) begin
            if (r_stg[LAST-1].dz) begin
                n_last.value = '0;
            end else if (r_stg[LAST-1].neg) begin
                n_last.value = ~r_stg[LAST-1].dq[DATA_W-1:0] + 1'b1;
            end else begin
                n_last.value = r_stg[LAST-1].dq[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stg[LAST] <= n_last;
        end
    end

    assign o_rsp.valid          = r_vld[LAST];
    assign o_rsp.value          = r_stg[LAST].value;
    assign o_rsp.compare_true   = r_stg[LAST].cmp;
    assign o_rsp.divide_by_zero = r_stg[LAST].dz;

endmodule

`default_nettype wire

// File: rtl/fixed_point_alu_top.sv
// The divider, one quotient bit per stage, sets the depth of the pipeline.
// Throughput: one item per cycle for every opcode while responses are taken;
// a four-entry queue decouples decode from the execution pipeline.
// Reset: synchronous, active low; clears all valid flags and queue pointers.
// ----------------------------------------------------------------------------
// fixed_point_alu_top: signed 32-bit fixed-point ALU
// Decode front, job queue and pipelined multiply/divide back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_top
    import fpa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fpa_req_if.sink     i_req,
    fpa_rsp_if.source   o_rsp
);

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    t_job  front_job;
    t_job  head_job;

    fpa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (front_job)
    );

    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    fpa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire

// File: rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker: port-level checks
// Consistency of the response flags and a stalled response beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [31:0] i_rsp_value,
    input wire logic        i_rsp_cmp,
    input wire logic        i_rsp_dz
);

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_cmp && i_rsp_dz))
        else $error("compare and divide-by-zero flags both set");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_cmp) |-> (i_rsp_value == 32'd0))
        else $error("true comparison with nonzero value");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_dz) |-> (i_rsp_value == 32'd0))
        else $error("divide by zero with nonzero value");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_cmp)
             && $stable(i_rsp_dz)))
        else $error("stalled response beat changed");

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_value (o_rsp.value),
    .i_rsp_cmp   (o_rsp.compare_true),
    .i_rsp_dz    (o_rsp.divide_by_zero)
);

`default_nettype wire
